// ----- design/pfr_pkg.sv -----
package pfr_pkg;

    // Widths of the fields carried along the cell chain. They cover the full
    // range of frame counts (up to 64) and page widths (up to 32 bits).
    localparam int MAX_IDX_W  = 6;
    localparam int MAX_RANK_W = 6;
    localparam int MAX_PAGE_W = 32;

    typedef logic [MAX_IDX_W-1:0]  t_idx;
    typedef logic [MAX_RANK_W-1:0] t_rank;
    typedef logic [MAX_PAGE_W-1:0] t_page;

    // Configuration register indexes.
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    // Replacement policy codes.
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Search record handed from one cell to the next.
    typedef struct packed {
        logic  tok;
        logic  hit;
        t_idx  hit_idx;
        t_rank hit_rank;
        logic  empty;
        t_idx  empty_idx;
        t_idx  lru_idx;
        t_rank lru_rank;
        t_page lru_page;
        t_rank ptr_rank;
        t_page ptr_page;
    } t_scan;

    // Update broadcast to every cell once the victim is known.
    typedef struct packed {
        logic  en;
        t_idx  frame;
        logic  was_valid;
        t_rank old_rank;
        logic  load;
        t_page page;
    } t_upd;

endpackage

// ----- design/pfr_cell.sv -----
module pfr_cell #(
    parameter int FRAME_COUNT = 16,
    parameter int PAGE_BITS   = 16,
    parameter int CELL_IDX    = 0,
    localparam int CW = $clog2(FRAME_COUNT + 1),
    localparam int RW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PAGE_BITS-1:0] i_req_page,
    input  logic [CW-1:0]        i_active_frames,
    input  pfr_pkg::t_idx        i_ptr,
    input  pfr_pkg::t_scan       i_rec,
    output pfr_pkg::t_scan       o_rec,
    input  pfr_pkg::t_upd        i_upd
);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [RW-1:0]        r_rank;
    logic                 r_tok;
    pfr_pkg::t_scan       r_rec;
    pfr_pkg::t_scan       n_rec;

    // Fold this frame into the running search record; frames beyond the
    // active count pass the record on untouched.
    always_comb begin
        n_rec = i_rec;
        if (CELL_IDX < int'(i_active_frames)) begin
            if (!i_rec.hit && r_valid && (r_page == i_req_page)) begin
                n_rec.hit      = 1'b1;
                n_rec.hit_idx  = pfr_pkg::t_idx'(CELL_IDX);
                n_rec.hit_rank = pfr_pkg::t_rank'(r_rank);
            end
            if (!i_rec.empty && !r_valid) begin
                n_rec.empty     = 1'b1;
                n_rec.empty_idx = pfr_pkg::t_idx'(CELL_IDX);
            end
            if ((CELL_IDX == 0) || (pfr_pkg::t_rank'(r_rank) > i_rec.lru_rank)) begin
                n_rec.lru_idx  = pfr_pkg::t_idx'(CELL_IDX);
                n_rec.lru_rank = pfr_pkg::t_rank'(r_rank);
                n_rec.lru_page = pfr_pkg::t_page'(r_page);
            end
            if (pfr_pkg::t_idx'(CELL_IDX) == i_ptr) begin
                n_rec.ptr_rank = pfr_pkg::t_rank'(r_rank);
                n_rec.ptr_page = pfr_pkg::t_page'(r_page);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_rec.tok;
        end
        if (i_rec.tok) begin
            r_rec <= n_rec;
        end
    end

    always_comb begin
        o_rec     = r_rec;
        o_rec.tok = r_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (i_upd.frame == pfr_pkg::t_idx'(CELL_IDX)) begin
                r_rank <= '0;
                if (i_upd.load) begin
                    r_valid <= 1'b1;
                end
            end else if (r_valid
                         && (!i_upd.was_valid
                             || (pfr_pkg::t_rank'(r_rank) < i_upd.old_rank))
                         && (int'(r_rank) < FRAME_COUNT - 1)) begin
                r_rank <= r_rank + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.load && (i_upd.frame == pfr_pkg::t_idx'(CELL_IDX))) begin
            r_page <= PAGE_BITS'(i_upd.page);
        end
    end

endmodule

// ----- design/page_frame_replacement_fifo_lru_unit.sv -----
// Requests are taken only in the idle state, so a new request waits until the last one is applied.
// The search token passes through each frame cell register in turn, then the last record is
// handed to the control, the update state (held while the result register is full) applies
// the choice and fills the result register, and the next request is accepted in idle.
// Reset (synchronous, active low): all frames empty, ranks, pointer and fault count zero,
// policy FIFO, sixteen frames in use, no result pending.
module page_frame_replacement_fifo_lru_unit #(
    parameter int FRAME_COUNT = 16,
    parameter int PAGE_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request transaction. tdata: request_page [15:0].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // Result transaction. tdata, from the lowest bit up: hit [0], frame_index [4:1],
    // evicted_valid [5], evicted_page [21:6], fault_total [53:22], zero fill [55:54].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int CW = $clog2(FRAME_COUNT + 1);
    localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    // Configuration registers.
    logic        r_policy;
    logic [4:0]  r_frames_cfg;

    // Per-request working registers, held steady while the token walks the chain.
    logic [1:0]           r_state;
    logic                 r_start;
    logic [PAGE_BITS-1:0] r_req_page;
    logic [CW-1:0]        r_active;
    pfr_pkg::t_idx        r_ptr_eff;

    // Architectural state kept outside the cells.
    logic [IW-1:0]  r_ptr;
    logic [31:0]    r_faults;

    // Result register, which parts the master side from the search.
    logic           r_out_valid;
    logic [55:0]    r_out_data;

    logic [CW-1:0]  active_now;
    logic           in_accept;
    logic           out_free;
    logic           apply_fire;

    pfr_pkg::t_scan chain [FRAME_COUNT+1];
    pfr_pkg::t_scan last_rec;
    pfr_pkg::t_upd  upd;

    logic           sel_evict;
    pfr_pkg::t_idx  sel_frame;
    pfr_pkg::t_page sel_ev_page;
    logic [31:0]    faults_next;

    // Effective frame count: zero acts as one, and anything above the built
    // count acts as the built count.
    always_comb begin
        if (r_frames_cfg == 5'd0) begin
            active_now = CW'(1);
        end else if (int'(r_frames_cfg) > FRAME_COUNT) begin
            active_now = CW'(FRAME_COUNT);
        end else begin
            active_now = CW'(r_frames_cfg);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign apply_fire    = (r_state == ST_APPLY) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= pfr_pkg::POLICY_FIFO;
            r_frames_cfg <= 5'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pfr_pkg::CFG_POLICY: r_policy     <= i_cfg_data[0];
                pfr_pkg::CFG_FRAMES: r_frames_cfg <= i_cfg_data;
                default:             r_policy     <= r_policy;
            endcase
        end
    end

    // The request is registered on acceptance, together with the frame count
    // and the round robin pointer folded back into range. The token enters
    // cell zero in the cycle after acceptance.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_page <= PAGE_BITS'(s_axis_tdata);
            r_active   <= active_now;
            if (int'(r_ptr) < int'(active_now)) begin
                r_ptr_eff <= pfr_pkg::t_idx'(r_ptr);
            end else begin
                r_ptr_eff <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= in_accept;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (last_rec.tok) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Head of the chain: an empty record carrying the token.
    always_comb begin
        chain[0]     = '0;
        chain[0].tok = r_start;
    end

    for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
        pfr_cell #(
            .FRAME_COUNT (FRAME_COUNT),
            .PAGE_BITS   (PAGE_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_req_page      (r_req_page),
            .i_active_frames (r_active),
            .i_ptr           (r_ptr_eff),
            .i_rec           (chain[g]),
            .o_rec           (chain[g+1]),
            .i_upd           (upd)
        );
    end

    // The last cell keeps its record until the next token, so the update
    // cycle may wait for the master side without losing the search result.
    assign last_rec = chain[FRAME_COUNT];

    // Victim choice: a hit keeps its frame, a miss takes the lowest empty
    // frame, and a full set evicts by policy. Under LRU the lowest-numbered
    // frame with the highest rank has already been picked along the chain.
    always_comb begin
        upd         = '0;
        sel_evict   = 1'b0;
        sel_ev_page = '0;
        priority if (last_rec.hit) begin
            sel_frame     = last_rec.hit_idx;
            upd.was_valid = 1'b1;
            upd.old_rank  = last_rec.hit_rank;
        end else if (last_rec.empty) begin
            sel_frame     = last_rec.empty_idx;
            upd.was_valid = 1'b0;
        end else if (r_policy == pfr_pkg::POLICY_FIFO) begin
            sel_frame     = r_ptr_eff;
            upd.was_valid = 1'b1;
            upd.old_rank  = last_rec.ptr_rank;
            sel_evict     = 1'b1;
            sel_ev_page   = last_rec.ptr_page;
        end else begin
            sel_frame     = last_rec.lru_idx;
            upd.was_valid = 1'b1;
            upd.old_rank  = last_rec.lru_rank;
            sel_evict     = 1'b1;
            sel_ev_page   = last_rec.lru_page;
        end
        upd.en    = apply_fire;
        upd.frame = sel_frame;
        upd.load  = !last_rec.hit;
        upd.page  = pfr_pkg::t_page'(r_req_page);
    end

    // Every fault bumps the count, which sticks at its maximum.
    always_comb begin
        if (!last_rec.hit && (r_faults != 32'hFFFF_FFFF)) begin
            faults_next = r_faults + 32'd1;
        end else begin
            faults_next = r_faults;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_faults <= '0;
        end else if (apply_fire) begin
            r_faults <= faults_next;
            // The pointer moves past the chosen frame on every fault,
            // under either policy, so a policy switch finds it current.
            if (!last_rec.hit) begin
                if (int'(sel_frame) + 1 >= int'(r_active)) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= IW'(int'(sel_frame) + 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_fire) begin
            r_out_data <= {2'b00, faults_next, 16'(sel_ev_page), sel_evict,
                           4'(sel_frame), last_rec.hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

// Testbench for the page frame replacement unit (FIFO or LRU victim choice).
//
// The initial block below builds the stimulus phase by phase. Each phase first
// programs the policy, the number of frames in use or both while the block is idle.
// It then queues a burst of page requests, which the driver feeds into the
// request stream. Every accepted request transaction is run through a local
// model of the frame table at the moment of acceptance. That model gives the
// expected result, which is queued. The monitor checks each result
// transaction, field by field, against the oldest queued expectation.
module testbench;

    localparam int FRAMES      = 16;
    localparam int CYCLE_LIMIT = 400000;

    // One result transaction, laid out so that hit sits in the lowest bit,
    // matching the packing of m_axis_tdata[53:0].
    typedef struct packed {
        logic [31:0] faults;
        logic [15:0] ev_page;
        logic        ev_valid;
        logic [3:0]  frame;
        logic        hit;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;      // request_page [15:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // hit [0], frame_index [4:1], evicted_valid [5], evicted_page [21:6],
    // fault_total [53:22], zero fill [55:54]
    logic [55:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = pfr_pkg::CFG_POLICY;
    logic [4:0]  i_cfg_data = '0;

    // Local copy of the frame table, the pointer, the fault count and the two configuration registers.
    logic [15:0] frame_page [FRAMES];
    bit          frame_valid [FRAMES];
    logic [3:0]  frame_rank [FRAMES];
    logic [3:0]  rr_ptr;
    logic [31:0] fault_total;
    logic        policy_sel;
    logic [4:0]  frames_sel;

    logic [15:0] pending_requests [$];
    t_result     expected_results [$];
    logic [15:0] page_pool [64];

    // When set, neither side idles: this gives one long back-to-back stretch.
    bit steady = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned hits_seen = 0;
    int unsigned evictions_seen = 0;
    int unsigned phases_run = 0;
    int unsigned mismatches = 0;

    page_frame_replacement_fifo_lru_unit #(
        .FRAME_COUNT(FRAMES),
        .PAGE_BITS  (16)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Mark frame f as most recently used. Valid frames that were more recent
    // than f (or all of them, if f was empty) age by one rank, saturating at
    // the oldest rank. This runs over every frame, even those above the count.
    function automatic void promote_frame(int f);
        bit         was_valid;
        logic [3:0] old_rank;
        was_valid = frame_valid[f];
        old_rank  = frame_rank[f];
        for (int j = 0; j < FRAMES; j++) begin
            if (j != f && frame_valid[j] && (!was_valid || frame_rank[j] < old_rank)
                    && frame_rank[j] != 4'hF) begin
                frame_rank[j]++;
            end
        end
        frame_rank[f] = '0;
    endfunction

    // Look up one page, choose its frame, update the table and return the result.
    function automatic t_result replace_page(logic [15:0] page);
        t_result    r;
        int         n;
        int         f;
        bit         found;
        logic [3:0] best;
        // A count of zero acts as one frame; counts above the array act as the array.
        n = (frames_sel == 0) ? 1 : ((frames_sel > FRAMES) ? FRAMES : int'(frames_sel));
        r = '0;
        f = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!found && frame_valid[i] && frame_page[i] == page) begin
                found = 1'b1;
                f = i;
            end
        end
        r.hit = found;
        if (!found) begin
            // Fill the lowest empty frame first.
            for (int i = 0; i < n; i++) begin
                if (!found && !frame_valid[i]) begin
                    found = 1'b1;
                    f = i;
                end
            end
            if (!found) begin
                if (policy_sel == pfr_pkg::POLICY_FIFO) begin
                    // A pointer left beyond a lowered count restarts at frame zero.
                    f = (rr_ptr < n) ? int'(rr_ptr) : 0;
                end else begin
                    // Oldest rank wins; ties go to the lowest frame.
                    best = '0;
                    f = 0;
                    for (int i = 0; i < n; i++) begin
                        if (i == 0 || frame_rank[i] > best) begin
                            best = frame_rank[i];
                            f = i;
                        end
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = frame_page[f];
            end
            promote_frame(f);
            frame_valid[f] = 1'b1;
            frame_page[f]  = page;
            rr_ptr = (f + 1 >= n) ? 4'd0 : 4'(f + 1);
            if (fault_total != '1) begin
                fault_total++;
            end
        end else begin
            promote_frame(f);
        end
        r.frame  = 4'(f);
        r.faults = fault_total;
        return r;
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            flag_error($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                                 results_seen, name, want, got));
        end
    endtask

    // Request driver. A new transaction is offered whenever the stream is free,
    // unless this cycle is chosen to idle. The expectation is computed at the
    // edge where the request is accepted.
    always @(posedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(replace_page(s_axis_tdata));
                requests_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_requests.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 36);
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got = m_axis_tdata[53:0];
                if (got.hit) hits_seen++;
                if (got.ev_valid) evictions_seen++;
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing expected: 0x%0h",
                                         results_seen, m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("frame_index", 32'(want.frame), 32'(got.frame));
                    check_field("evicted_valid", 32'(want.ev_valid), 32'(got.ev_valid));
                    check_field("evicted_page", 32'(want.ev_page), 32'(got.ev_page));
                    check_field("fault_total", want.faults, got.faults);
                    check_field("zero fill", 32'd0, 32'(m_axis_tdata[55:54]));
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Register write; the local copy follows at once, since the block is idle.
    task automatic write_reg(logic index, logic [4:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == pfr_pkg::CFG_POLICY) begin
            policy_sel = value[0];
        end else begin
            frames_sel = value;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every queued request has been sent and answered, then let
    // the frame chain run empty before anything else changes.
    task automatic drain;
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (FRAMES + 8) @(posedge i_clk);
        phases_run++;
    endtask

    // Requests drawn mostly from a small pool of random pages, so hits and
    // evictions both happen often; about one in ten is a fresh random page.
    task automatic queue_random_pages(int count, int pool_size);
        for (int k = 0; k < pool_size; k++) begin
            page_pool[k] = 16'($urandom_range(16'hFFFF));
        end
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0) begin
                pending_requests.push_back(16'($urandom_range(16'hFFFF)));
            end else begin
                pending_requests.push_back(page_pool[$urandom_range(pool_size - 1)]);
            end
        end
    endtask

    initial begin
        int frame_plan [14];
        int eff;
        frame_plan = '{1, 2, 3, 4, 5, 7, 8, 12, 15, 16, 0, 17, 31, 6};

        // Local state matches the reset state of the block.
        for (int i = 0; i < FRAMES; i++) begin
            frame_page[i]  = '0;
            frame_valid[i] = 1'b0;
            frame_rank[i]  = '0;
        end
        rr_ptr      = '0;
        fault_total = '0;
        policy_sel  = pfr_pkg::POLICY_FIFO;
        frames_sel  = 5'd16;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // FIFO over all sixteen frames: extreme pages, a hit, fill every frame,
        // then two evictions in round-robin order and one more hit.
        write_reg(pfr_pkg::CFG_POLICY, pfr_pkg::POLICY_FIFO);
        write_reg(pfr_pkg::CFG_FRAMES, 5'd16);
        pending_requests.push_back(16'h0000);
        pending_requests.push_back(16'hFFFF);
        pending_requests.push_back(16'h0000);
        for (int p = 1; p <= 14; p++) begin
            pending_requests.push_back(16'(p));
        end
        pending_requests.push_back(16'h8000);
        pending_requests.push_back(16'h0000);
        pending_requests.push_back(16'h000E);
        drain();

        // LRU after lowering the count to three. Page 5 sits in a frame above
        // the count, so it must miss and be loaded again below it.
        write_reg(pfr_pkg::CFG_POLICY, pfr_pkg::POLICY_LRU);
        write_reg(pfr_pkg::CFG_FRAMES, 5'd3);
        pending_requests.push_back(16'h0005);
        pending_requests.push_back(16'h8000);
        pending_requests.push_back(16'h7777);
        drain();

        // A count of zero behaves as a single frame.
        write_reg(pfr_pkg::CFG_FRAMES, 5'd0);
        pending_requests.push_back(16'h8000);
        pending_requests.push_back(16'h8000);
        drain();

        // A count beyond the array behaves as the full array.
        write_reg(pfr_pkg::CFG_FRAMES, 5'd31);
        pending_requests.push_back(16'h0005);
        drain();

        // Random phases over many frame counts and both policies. The policy
        // switches without clearing the table, and one phase runs with no idling.
        for (int p = 0; p < 14; p++) begin
            write_reg(pfr_pkg::CFG_POLICY, (p < 2) ? 1'(p) : 1'($urandom_range(1)));
            write_reg(pfr_pkg::CFG_FRAMES, 5'(frame_plan[p]));
            eff = (frame_plan[p] == 0) ? 1 : ((frame_plan[p] > FRAMES) ? FRAMES : frame_plan[p]);
            steady = (p == 9);
            queue_random_pages((p == 9) ? 150 : 65, eff + 1 + $urandom_range(eff + 2));
            drain();
            steady = 1'b0;
        end

        if (expected_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("Ran %0d phases: %0d requests in, %0d results checked, %0d mismatches.",
                 phases_run, requests_sent, results_seen, mismatches);
        $display("Results seen: %0d hits, %0d evictions, final fault count %0d.",
                 hits_seen, evictions_seen, fault_total);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/pfr_pkg.sv
design/pfr_cell.sv
design/page_frame_replacement_fifo_lru_unit.sv
test/testbench.sv
